// ===== hdl/pfdp_pkg.sv =====
// package for the proportional fair destination picker
// opcodes, status codes, sizes and the log2 step helper; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pfdp_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);

  localparam logic [1:0] OP_SELECT = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SERVED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SLOT  = 2'd2;

  localparam logic [0:0] CFG_ALPHA = 1'b0;
  localparam logic [0:0] CFG_BETA  = 1'b1;

  // score: alpha/beta Q4.4 times Q8.8 logs, 12 fraction bits
  localparam int unsigned ScoreW = 36;

  typedef struct packed {
    logic load;      // latch the beat, start work
    logic upd;       // write the slot table for add/remove/served
    logic scan_step; // evaluate one slot of the select scan
    logic scan_clr;  // reset scan index and best
    logic finish;    // take the scan result into the output register
  } pfdp_cmd_t;

  typedef struct packed {
    logic scan_last;   // final slot of the scan is in flight
    logic log_done;    // log units have finished
  } pfdp_sts_t;

  // one squaring round of the fractional log2
  function automatic logic [16:0] sq_step(input logic [15:0] m);
    logic [31:0] p;
    logic [16:0] r;
    p = m * m;
    r = p[31:15];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/pfdp_log2.sv =====
// iterative log2 of a 48 bit value into unsigned Q8.8
// uses pfdp_pkg; one squaring round per cycle after a leading-one search
`timescale 1ns / 1ps
`default_nettype none
module pfdp_log2
  import pfdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] x_i,
  output logic             done_o,
  output logic [15:0]      log_o
);
  logic [47:0] x_q, x_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] m_q, m_d;
  logic [7:0]  frac_q, frac_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  ph_q, ph_d;
  logic [5:0]  lz;
  logic [16:0] sq;
  logic [47:0] xn;
  logic [62:0] sh;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  always_comb begin
    lz = '0;
    for (int i = 0; i < 48; i++) begin
      if (x_q[i]) lz = 6'(i);
    end
  end

  assign xn = (x_i == '0) ? 48'd1 : x_i;
  assign sh = ({15'd0, x_q} << 15) >> lz;
  assign sq = sq_step(m_q);

  always_comb begin
    x_d = x_q;
    pos_d = pos_q;
    m_d = m_q;
    frac_d = frac_q;
    cnt_d = cnt_q;
    ph_d = ph_q;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          x_d = xn;
          ph_d = PH_NORM;
        end
      end
      PH_NORM: begin
        pos_d = lz;
        m_d = sh[15:0];
        frac_d = '0;
        cnt_d = '0;
        ph_d = PH_SQ;
      end
      PH_SQ: begin
        if (sq[16]) begin
          m_d = sq[16:1];
          frac_d = {frac_q[6:0], 1'b1};
        end else begin
          m_d = sq[15:0];
          frac_d = {frac_q[6:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) ph_d = PH_DONE;
      end
      PH_DONE: begin
        if (start_i) begin
          x_d = xn;
          ph_d = PH_NORM;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    pos_q <= pos_d;
    m_q <= m_d;
    frac_q <= frac_d;
    cnt_q <= cnt_d;
  end

  assign done_o = (ph_q == PH_DONE) && !start_i;
  assign log_o = {2'b00, pos_q, frac_q};
endmodule
`default_nettype wire

// ===== hdl/pfdp_datapath.sv =====
// slot table, log2 units, score compare and result register
// uses pfdp_pkg and pfdp_log2; driven by pfdp_ctrl commands
`timescale 1ns / 1ps
`default_nettype none
module pfdp_datapath
  import pfdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pfdp_cmd_t   cmd_i,
  output pfdp_sts_t        sts_o,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [31:0] latency_i,
  input  wire logic [47:0] now_i,
  input  wire logic        log_start_i,
  output logic [3:0]       chosen_slot_o,
  output logic             choice_valid_o,
  output logic [1:0]       status_o
);
  logic [Slots-1:0] valid_q;
  logic [31:0] cnt_mem [Slots];
  logic [47:0] time_mem [Slots];
  logic [31:0] lat_mem [Slots];
  logic [7:0]  alpha_q, beta_q;
  logic [1:0]  op_q;
  logic [3:0]  slot_q;
  logic [31:0] lat_q;
  logic [47:0] now_q;
  logic [SlotW-1:0] idx_q;
  logic [31:0] rd_cnt_q, rd_lat_q;
  logic [47:0] rd_time_q;
  logic        rd_valid_q;
  logic        found_q;
  logic signed [ScoreW+15:0] best_q, sc;
  logic [SlotW-1:0] best_idx_q;
  logic [15:0] l_lat, l_cnt, l_el;
  logic        d_lat, d_cnt, d_el;
  logic        present;
  logic [SlotW-1:0] s;
  logic        in_range;
  logic [3:0]  chosen_q;
  logic        cv_q;
  logic [1:0]  st_q;
  logic [1:0]  upd_st_q;

  assign in_range = ({2'b00, slot_q} < 6'(Slots));
  assign s = slot_q[SlotW-1:0];
  assign present = in_range && valid_q[s];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 8'd16;
      beta_q <= 8'd16;
      valid_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ALPHA) alpha_q <= cfg_data_i;
        else beta_q <= cfg_data_i;
      end
      if (cmd_i.upd) begin
        unique case (op_q)
          OP_ADD:    if (in_range && !present) valid_q[s] <= 1'b1;
          OP_REMOVE: if (present) valid_q[s] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      slot_q <= slot_i;
      lat_q <= latency_i;
      now_q <= now_i;
    end
    if (cmd_i.upd) begin
      if (op_q == OP_ADD) upd_st_q <= (in_range && !present) ? ST_OK : ST_SLOT;
      else upd_st_q <= present ? ST_OK : ST_SLOT;
      if (op_q == OP_ADD && in_range && !present) begin
        cnt_mem[s] <= 32'd1;
        time_mem[s] <= now_q;
        lat_mem[s] <= lat_q;
      end else if (op_q == OP_SERVED && present) begin
        if (rd_cnt_q != 32'hFFFF_FFFF) cnt_mem[s] <= rd_cnt_q + 32'd1;
        time_mem[s] <= now_q;
        lat_mem[s] <= lat_q;
      end
    end
  end

  // registered read at the scan index, or at the beat's slot for updates
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_cnt_q <= cnt_mem[slot_i[SlotW-1:0]];
    end else begin
      rd_cnt_q <= cnt_mem[idx_q];
      rd_lat_q <= lat_mem[idx_q];
      rd_time_q <= time_mem[idx_q];
      rd_valid_q <= valid_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) idx_q <= '0;
    else if (cmd_i.scan_step) idx_q <= idx_q + 1'b1;
  end

  pfdp_log2 u_log_lat (
    .clk_i, .rst_ni, .start_i(log_start_i),
    .x_i({16'd0, rd_lat_q}), .done_o(d_lat), .log_o(l_lat)
  );
  pfdp_log2 u_log_cnt (
    .clk_i, .rst_ni, .start_i(log_start_i),
    .x_i({16'd0, rd_cnt_q}), .done_o(d_cnt), .log_o(l_cnt)
  );
  pfdp_log2 u_log_el (
    .clk_i, .rst_ni, .start_i(log_start_i),
    .x_i(now_q - rd_time_q), .done_o(d_el), .log_o(l_el)
  );

  logic signed [17:0] a_term, b_term;
  always_comb begin
    a_term = $signed({2'b00, l_lat}) - 18'sd4096;
    b_term = $signed({2'b00, l_cnt}) - $signed({2'b00, l_el});
    if (now_q <= rd_time_q) sc = -(52'sd1 <<< 50);
    else sc = -(52'($signed({1'b0, alpha_q}) * a_term))
              - 52'($signed({1'b0, beta_q}) * b_term);
  end

  assign sts_o.log_done = d_lat && d_cnt && d_el;
  assign sts_o.scan_last = (idx_q == SlotW'(Slots - 1));

  // compare step evaluates the slot whose data sits in the read registers
  logic [SlotW-1:0] cur_idx_q;
  always_ff @(posedge clk_i) begin
    if (log_start_i) cur_idx_q <= idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_step && rd_valid_q) begin
      if (!found_q || sc > best_q) begin
        found_q <= 1'b1;
        best_q <= sc;
        best_idx_q <= cur_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (op_q == OP_SELECT) begin
        chosen_q <= found_q ? 4'(best_idx_q) : 4'd0;
        cv_q <= found_q;
        st_q <= found_q ? ST_OK : ST_EMPTY;
      end else begin
        chosen_q <= 4'd0;
        cv_q <= 1'b0;
        st_q <= upd_st_q;
      end
    end
  end

  assign chosen_slot_o = chosen_q;
  assign choice_valid_o = cv_q;
  assign status_o = st_q;
endmodule
`default_nettype wire

// ===== hdl/pfdp_ctrl.sv =====
// controller for the picker: handshakes and scan sequencing
// uses pfdp_pkg; drives pfdp_datapath through pfdp_cmd_t
`timescale 1ns / 1ps
`default_nettype none
module pfdp_ctrl
  import pfdp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode_i,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire pfdp_sts_t  sts_i,
  output pfdp_cmd_t       cmd_o,
  output logic            log_start_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LOG  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_LS   = 3'd6;

  logic [2:0] st_q, st_d;
  logic       ov_q, ov_d;
  logic       last_q, last_d;
  logic       acc;

  assign in_ready = (st_q == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = ov_q;

  always_comb begin
    st_d = st_q;
    ov_d = ov_q;
    last_d = last_q;
    cmd_o = '0;
    log_start_o = 1'b0;
    if (ov_q && out_ready) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clr = 1'b1;
          st_d = (opcode_i == OP_SELECT) ? S_RD : S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        st_d = S_FIN;
      end
      S_RD: begin
        last_d = sts_i.scan_last;
        st_d = S_LS;
      end
      S_LS: begin
        log_start_o = 1'b1;
        st_d = S_LOG;
      end
      S_LOG: begin
        if (sts_i.log_done) st_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.scan_step = 1'b1;
        if (last_q) begin
          st_d = S_FIN;
        end else begin
          st_d = S_RD;
        end
      end
      S_FIN: begin
        if (!ov_q || out_ready) begin
          cmd_o.finish = 1'b1;
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      last_q <= last_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/proportional_fair_destination_picker.sv =====
// Proportional fair destination picker, top level.
// Uses pfdp_pkg, pfdp_ctrl and pfdp_datapath.
//
// Input channel (in_valid/in_ready) carries opcode, slot, latency and now.
// Every beat yields exactly one result beat on out_valid/out_ready with
// chosen_slot, choice_valid and status.
// Add, remove and served go through update, then finish raises out_valid.
// Select scans every slot: per slot one table read, one log2 start, one
// leading-one search and eight squaring rounds in the three log2 units, one
// done state and one compare.
// One item is in the block at a time; the next beat is taken once the
// result is in the output register, while that result may still wait.
// A stalled receiver holds the result; work finishes and waits for it.
// Reset clears the valid marks, the handshake state and sets both exponents
// to 1.0. Configuration beats on cfg_valid/cfg_ready are always taken and
// apply at once, so they must be sent only while no item is in flight;
// the block does not enforce this. Index 0 writes alpha, 1 beta.
`timescale 1ns / 1ps
`default_nettype none
module proportional_fair_destination_picker
  import pfdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [31:0] latency_i,
  input  wire logic [47:0] now_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       chosen_slot_o,
  output logic             choice_valid_o,
  output logic [1:0]       status_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  pfdp_cmd_t cmd;
  pfdp_sts_t sts;
  logic      log_start;

  assign cfg_ready = 1'b1;

  pfdp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .opcode_i,
    .out_valid, .out_ready, .sts_i(sts), .cmd_o(cmd), .log_start_o(log_start)
  );

  pfdp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i(cfg_valid), .cfg_index_i, .cfg_data_i,
    .opcode_i, .slot_i, .latency_i, .now_i, .log_start_i(log_start),
    .chosen_slot_o, .choice_valid_o, .status_o
  );
endmodule
`default_nettype wire

// ===== tb/proportional_fair_destination_picker_test.sv =====
// testbench for the proportional fair destination picker: directed and random
// beats, a scoreboard class that predicts every result; uses pfdp_pkg
`timescale 1ns / 1ps
module proportional_fair_destination_picker_test;
  import pfdp_pkg::*;

  typedef struct {
    logic [3:0] chosen;
    logic       cv;
    logic [1:0] status;
  } pick_result_t;

  class pick_scoreboard;
    bit           live[16];
    int unsigned  count[16];
    logic [47:0]  stamp[16];
    int unsigned  lat[16];
    logic [7:0]   alpha;
    logic [7:0]   beta;
    pick_result_t pending[$];
    int           errors;

    function new();
      alpha = 8'd16;
      beta = 8'd16;
      errors = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function longint log2_q88(logic [63:0] x);
      int         pos;
      logic [63:0] m;
      logic [7:0] frac;
      pos = 0;
      frac = 0;
      if (x == 0) x = 1;
      for (int b = 0; b < 64; b++) if (x[b]) pos = b;
      m = (pos >= 15) ? (x >> (pos - 15)) : (x << (15 - pos));
      for (int r = 0; r < 8; r++) begin
        m = (m * m) >> 15;
        if (m >= 64'd65536) begin
          frac = {frac[6:0], 1'b1};
          m = m >> 1;
        end else begin
          frac = {frac[6:0], 1'b0};
        end
      end
      return longint'(pos) * 256 + longint'(frac);
    endfunction

    function longint fair_score(int s, logic [47:0] now);
      longint l_lat;
      longint l_cnt;
      longint l_el;
      if (now <= stamp[s]) return -(longint'(1) << 50);
      l_lat = log2_q88(lat[s] == 0 ? 64'd1 : 64'(lat[s])) - 4096;
      l_cnt = log2_q88(count[s] == 0 ? 64'd1 : 64'(count[s]));
      l_el = log2_q88(64'(now - stamp[s]));
      return -(longint'(alpha) * l_lat) - longint'(beta) * (l_cnt - l_el);
    endfunction

    function void note_beat(logic [1:0] op, logic [3:0] s, logic [31:0] l,
                            logic [47:0] now);
      pick_result_t r;
      bit           found;
      longint       best;
      longint       sc;
      r.chosen = 0;
      r.cv = 0;
      r.status = ST_OK;
      found = 0;
      best = 0;
      case (op)
        OP_SELECT: begin
          for (int i = 0; i < 16; i++) begin
            if (live[i]) begin
              sc = fair_score(i, now);
              if (!found || sc > best) begin
                found = 1;
                best = sc;
                r.chosen = 4'(i);
              end
            end
          end
          if (found) r.cv = 1;
          else r.status = ST_EMPTY;
        end
        OP_ADD: begin
          if (live[s]) begin
            r.status = ST_SLOT;
          end else begin
            live[s] = 1;
            count[s] = 1;
            stamp[s] = now;
            lat[s] = l;
          end
        end
        OP_REMOVE: begin
          if (!live[s]) r.status = ST_SLOT;
          else live[s] = 0;
        end
        default: begin
          if (!live[s]) begin
            r.status = ST_SLOT;
          end else begin
            if (count[s] != 32'hffff_ffff) count[s]++;
            stamp[s] = now;
            lat[s] = l;
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [3:0] chosen, logic cv, logic [1:0] status);
      pick_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = pending.pop_front();
        if (chosen !== e.chosen)
          report_mismatch($sformatf("chosen_slot %0d, want %0d", chosen, e.chosen));
        if (cv !== e.cv)
          report_mismatch($sformatf("choice_valid %0b, want %0b", cv, e.cv));
        if (status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", status, e.status));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [3:0]  slot;
  logic [31:0] latency;
  logic [47:0] now;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  chosen_slot;
  logic        choice_valid;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  pick_scoreboard sb = new();
  bit          quiet;
  bit          hold_req;
  logic [47:0] cur_now;
  int          stall_cycles;

  proportional_fair_destination_picker dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode_i(opcode), .slot_i(slot), .latency_i(latency), .now_i(now),
    .out_valid(out_valid), .out_ready(out_ready),
    .chosen_slot_o(chosen_slot), .choice_valid_o(choice_valid), .status_o(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, one long hold on request
  initial begin
    out_ready <= 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (800) @(posedge clk);
        hold_req = 0;
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(chosen_slot, choice_valid, status);
  end

  // watchdog on cycles with no beat on any channel
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task send_beat(logic [1:0] op, logic [3:0] s, logic [31:0] l, logic [47:0] t);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    slot <= s;
    latency <= l;
    now <= t;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_beat(op, s, l, t);
  endtask

  task write_reg(logic idx, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if (idx == CFG_ALPHA) sb.alpha = data;
    else sb.beta = data;
  endtask

  task drain;
    in_valid <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (250) @(posedge clk);
  endtask

  function logic [3:0] pick_slot(bit want_live);
    logic [3:0] s;
    for (int k = 0; k < 24; k++) begin
      s = 4'($urandom_range(0, 15));
      if (sb.live[s] == want_live) return s;
    end
    return s;
  endfunction

  task random_beat;
    logic [1:0]  op;
    logic [3:0]  s;
    logic [31:0] l;
    logic [47:0] t;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_SELECT;
    else if (r < 55) op = OP_ADD;
    else if (r < 65) op = OP_REMOVE;
    else op = OP_SERVED;
    s = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                    : pick_slot(op != OP_ADD);
    l = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 40) == 0) l = 0;
    r = $urandom_range(0, 99);
    if (r < 3) cur_now = 48'({$urandom, $urandom});
    else if (r < 30) cur_now = cur_now + 48'($urandom_range(0, 3));
    else cur_now = cur_now + 48'($urandom_range(1, 200000));
    t = cur_now;
    if ($urandom_range(0, 19) == 0) t = cur_now - 48'($urandom_range(0, 1000));
    send_beat(op, s, l, t);
  endtask

  logic [7:0] alpha_set[7] = '{8'd16, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
  logic [7:0] beta_set[7]  = '{8'd16, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};

  initial begin
    rst_n = 0;
    in_valid <= 0;
    opcode <= OP_SELECT;
    slot <= 0;
    latency <= 0;
    now <= 0;
    cfg_valid <= 0;
    cfg_index <= CFG_ALPHA;
    cfg_data <= 0;
    quiet = 0;
    hold_req = 0;
    stall_cycles = 0;
    cur_now = 0;
    repeat (6) @(posedge clk);
    rst_n = 1;
    @(posedge clk);

    // empty table, absent slots, zero elapsed time, extremes of fields
    send_beat(OP_SELECT, 0, 0, 0);
    send_beat(OP_REMOVE, 3, 0, 0);
    send_beat(OP_SERVED, 15, 1, 0);
    send_beat(OP_ADD, 0, 0, 48'd0);
    send_beat(OP_ADD, 0, 32'd5, 48'd1);
    send_beat(OP_SELECT, 0, 0, 48'd0);
    send_beat(OP_ADD, 15, 32'hffff_ffff, 48'd0);
    send_beat(OP_SELECT, 0, 0, 48'd0);
    send_beat(OP_SELECT, 0, 0, 48'd10);
    send_beat(OP_ADD, 7, 32'h0001_0000, 48'd0);
    send_beat(OP_SELECT, 0, 0, 48'hffff_ffff_ffff);
    send_beat(OP_SERVED, 7, 32'h0000_0001, 48'd20);
    send_beat(OP_SERVED, 7, 32'h0000_0001, 48'd30);
    send_beat(OP_SELECT, 0, 0, 48'd40);
    send_beat(OP_ADD, 8, 32'h0001_0000, 48'd0);
    send_beat(OP_SELECT, 0, 0, 48'd100);
    send_beat(OP_REMOVE, 0, 0, 48'd101);
    send_beat(OP_REMOVE, 0, 0, 48'd102);
    send_beat(OP_SELECT, 0, 0, 48'h8000_0000_0000);
    send_beat(OP_SERVED, 8, 32'haaaa_5555, 48'hffff_ffff_fff0);
    send_beat(OP_SELECT, 0, 0, 48'hffff_ffff_ffff);
    cur_now = 48'd200;

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      if (ph >= 5) begin
        alpha_set[ph] = 8'($urandom);
        beta_set[ph] = 8'($urandom);
      end
      write_reg(CFG_ALPHA, alpha_set[ph]);
      write_reg(CFG_BETA, beta_set[ph]);
      cfg_valid <= 0;
      quiet = (ph == 6);
      for (int n = 0; n < 250; n++) begin
        if (ph == 1 && n == 40) hold_req = 1;
        random_beat();
      end
    end
    in_valid <= 0;

    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (250) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
